FILE: rtl/core/fat_chain_entry_generator_macros.svh
// ----------------------------------------------------------------------------
// fat chain entry generator assertion macros
// shared property forms for the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_ENTRY_GENERATOR_MACROS_SVH
`define FAT_CHAIN_ENTRY_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FCEG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FCEG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fceg_pkg.sv
// ----------------------------------------------------------------------------
// fceg_pkg
// shared constants, codes and helpers of the fat chain entry generator
// ----------------------------------------------------------------------------
`default_nettype none

package fceg_pkg;

  localparam int MAX_FILES = 16;
  localparam int FIDX_W    = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CNT_W     = $clog2(MAX_FILES + 1);

  localparam int START_W   = 28;
  localparam int CLUST_W   = 24;
  localparam int ENTRY_W   = 28;
  localparam int RAM_W     = START_W + CLUST_W;

  localparam logic [ENTRY_W-1:0] MARK_MEDIA = 28'h0ffffff8;
  localparam logic [ENTRY_W-1:0] MARK_END   = 28'h0fffffff;
  localparam logic [ENTRY_W-1:0] MARK_BAD   = 28'h0ffffff7;
  localparam logic [1:0]         FIRST_DATA = 2'd2;
  localparam logic [4:0]         MIN_SHIFT  = 5'd9;

  // input item modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EXH   = 2'd2;

  // fat types
  localparam logic [1:0] FAT12      = 2'd0;

  // register indexes
  localparam logic [1:0] CFG_FAT_TYPE  = 2'd0;
  localparam logic [1:0] CFG_SHIFT     = 2'd1;
  localparam logic [1:0] CFG_ROOT      = 2'd2;

  // entry mask by fat type, type 3 behaves as fat32
  function automatic logic [ENTRY_W-1:0] entry_mask(input logic [1:0] ft);
    logic [ENTRY_W-1:0] m;
    if (ft[1]) begin
      m = 28'hfffffff;
    end else if (ft == FAT12) begin
      m = 28'h0000fff;
    end else begin
      m = 28'h000ffff;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fceg_ram.sv
// ----------------------------------------------------------------------------
// fceg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module fceg_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                                wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [W-1:0]                                rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fat_chain_entry_generator.sv
// ----------------------------------------------------------------------------
// fat_chain_entry_generator
// synthesises fat entries for files laid out as contiguous cluster runs
// ----------------------------------------------------------------------------
// Each input transfer gives exactly one result transfer. A clear or an unused
// mode goes straight to the done state. A load first checks the table and
// rounds the size to clusters with the shifter, then checks the run against
// the cluster limit and writes the file table. A query ends at the fixed-entry
// check when it hits a fixed entry or the fat32 root chain, or when the file
// table is empty. Otherwise it walks the table until a hit on file i or a miss
// past the last loaded file: the file table sits in a ram read once per cycle
// and a single subtract/compare unit walks it in order, one read ahead of the
// compare. The next item is taken as soon as the sequencer is back in idle,
// even while a result still waits on a stalled output. The file table has no
// reset; only entries below the loaded count are ever read.
`default_nettype none

`include "fat_chain_entry_generator_macros.svh"

module fat_chain_entry_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_file_size,
  input  wire logic [27:0] in_entry_index,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [27:0] out_entry_value,
  output logic             out_in_file,
  output logic      [3:0]  out_file_index,
  output logic      [27:0] out_first_cluster,
  output logic      [1:0]  out_status,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LCALC = 3'd1;
  localparam logic [2:0] ST_LCHK  = 3'd2;
  localparam logic [2:0] ST_QFIX  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int FIDX_W  = fceg_pkg::FIDX_W;
  localparam int CNT_W   = fceg_pkg::CNT_W;
  localparam int START_W = fceg_pkg::START_W;
  localparam int CLUST_W = fceg_pkg::CLUST_W;
  localparam int ENTRY_W = fceg_pkg::ENTRY_W;
  localparam int RAM_W   = fceg_pkg::RAM_W;

  // control state
  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   files_loaded_r, files_loaded_nxt;
  logic [START_W-1:0] offset_r, offset_nxt;
  logic [CNT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               out_valid_r, out_valid_nxt;

  // configuration registers
  logic [1:0]  fat_type_r;
  logic [4:0]  cluster_shift_r;
  logic [15:0] root_clusters_r;

  // item payload and working registers
  logic [31:0]        size_r;
  logic [27:0]        e_r;
  logic [28:0]        e_p1_r;
  logic [CLUST_W-1:0] clusters_r, clusters_nxt;
  logic [28:0]        start_r, start_nxt;
  logic [FIDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;

  // pending result
  logic [ENTRY_W-1:0] res_value_r, res_value_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [FIDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic [START_W-1:0] res_first_r, res_first_nxt;
  logic [1:0]         res_status_r, res_status_nxt;

  // output register
  logic [ENTRY_W-1:0] out_value_r;
  logic               out_hit_r;
  logic [FIDX_W-1:0]  out_idx_r;
  logic [START_W-1:0] out_first_r;
  logic [1:0]         out_status_r;

  logic in_acc;
  logic out_free;

  // ram interface
  logic               ram_we;
  logic               ram_re;
  logic [RAM_W-1:0]   ram_rdata;

  // derived config values
  logic               fat32;
  logic [ENTRY_W-1:0] mask;
  logic [16:0]        root_end;
  logic [4:0]         shift_eff;

  // datapath arithmetic
  logic [31:0]        size_q;
  logic [31:0]        size_low_mask;
  logic               size_rem;
  logic [29:0]        run_end;
  logic [29:0]        limit;
  logic [START_W-1:0] scan_s;
  logic [CLUST_W-1:0] scan_n;
  logic [28:0]        scan_d;
  logic               scan_hit;
  logic               scan_last;
  logic               scan_issue;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign fat32     = fat_type_r[1];
  assign mask      = fceg_pkg::entry_mask(fat_type_r);
  assign root_end  = {15'd0, fceg_pkg::FIRST_DATA} + (fat32 ? {1'b0, root_clusters_r} : 17'd0);
  assign shift_eff = (cluster_shift_r < fceg_pkg::MIN_SHIFT) ? fceg_pkg::MIN_SHIFT
                                                             : cluster_shift_r;

  // size rounded up to whole clusters
  assign size_q        = size_r >> shift_eff;
  assign size_low_mask = ~(32'hffff_ffff << shift_eff);
  assign size_rem      = |(size_r & size_low_mask);

  // end of the candidate run, one past its last cluster, against the limit of the fat type
  assign run_end = {1'b0, start_r} + {6'd0, clusters_r};
  assign limit   = {2'b0, mask} - 30'd8;

  // file table compare: offset of the cluster into the run read last cycle
  assign scan_s     = ram_rdata[RAM_W-1:CLUST_W];
  assign scan_n     = ram_rdata[CLUST_W-1:0];
  assign scan_d     = {1'b0, e_r} - {1'b0, scan_s};
  assign scan_hit   = cmp_vld_r && !scan_d[28] && (scan_n != '0)
                      && (scan_d[27:0] < {4'd0, scan_n});
  assign scan_last  = (scan_d[27:0] == {4'd0, scan_n - 24'd1});
  assign scan_issue = (state_r == ST_SCAN) && (scan_cnt_r < files_loaded_r);

  assign ram_re = scan_issue;
  assign ram_we = (state_r == ST_LCHK) && ((clusters_r == '0) || (run_end <= limit));

  fceg_ram #(
    .W     (RAM_W),
    .DEPTH (fceg_pkg::MAX_FILES)
  ) u_file_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (files_loaded_r[FIDX_W-1:0]),
    .wdata ({start_r[START_W-1:0], clusters_r}),
    .re    (ram_re),
    .raddr (scan_cnt_r[FIDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    files_loaded_nxt = files_loaded_r;
    offset_nxt       = offset_r;
    scan_cnt_nxt     = scan_cnt_r;
    cmp_vld_nxt      = cmp_vld_r;
    cmp_idx_nxt      = cmp_idx_r;
    out_valid_nxt    = out_valid_r && out_stall;
    clusters_nxt     = clusters_r;
    start_nxt        = start_r;
    res_value_nxt    = res_value_r;
    res_hit_nxt      = res_hit_r;
    res_idx_nxt      = res_idx_r;
    res_first_nxt    = res_first_r;
    res_status_nxt   = res_status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_value_nxt  = '0;
          res_hit_nxt    = 1'b0;
          res_idx_nxt    = '0;
          res_first_nxt  = '0;
          res_status_nxt = fceg_pkg::STAT_OK;
          unique case (in_mode)
            fceg_pkg::MODE_CLEAR: begin
              files_loaded_nxt = '0;
              offset_nxt       = '0;
              state_nxt        = ST_DONE;
            end
            fceg_pkg::MODE_LOAD:  state_nxt = ST_LCALC;
            fceg_pkg::MODE_QUERY: state_nxt = ST_QFIX;
            fceg_pkg::MODE_NONE:  state_nxt = ST_DONE;
            default:              state_nxt = ST_DONE;
          endcase
        end
      end

      ST_LCALC: begin
        if (files_loaded_r >= CNT_W'(fceg_pkg::MAX_FILES)) begin
          res_status_nxt = fceg_pkg::STAT_FULL;
          state_nxt      = ST_DONE;
        end else begin
          // quotient fits 23 bits, carry from the remainder fits the 24th
          clusters_nxt = CLUST_W'(size_q) + {{(CLUST_W-1){1'b0}}, size_rem};
          start_nxt    = {12'd0, root_end} + {1'b0, offset_r};
          state_nxt    = ST_LCHK;
        end
      end

      ST_LCHK: begin
        res_idx_nxt = files_loaded_r[FIDX_W-1:0];
        if (ram_we) begin
          files_loaded_nxt = files_loaded_r + CNT_W'(1);
          offset_nxt       = offset_r + {4'd0, clusters_r};
          res_first_nxt    = (clusters_r != '0) ? start_r[START_W-1:0] : '0;
        end else begin
          res_status_nxt = fceg_pkg::STAT_EXH;
        end
        state_nxt = ST_DONE;
      end

      ST_QFIX: begin
        scan_cnt_nxt = '0;
        cmp_vld_nxt  = 1'b0;
        if (e_r == 28'd0) begin
          res_value_nxt = fceg_pkg::MARK_MEDIA;
          state_nxt     = ST_DONE;
        end else if (e_r == 28'd1) begin
          res_value_nxt = fceg_pkg::MARK_END;
          state_nxt     = ST_DONE;
        end else if (fat32 && (e_r < {11'd0, root_end})) begin
          // inside the root directory chain
          res_value_nxt = (e_p1_r < {12'd0, root_end}) ? e_p1_r[27:0] : fceg_pkg::MARK_END;
          state_nxt     = ST_DONE;
        end else begin
          res_value_nxt = fceg_pkg::MARK_BAD;
          state_nxt     = (files_loaded_r == '0) ? ST_DONE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (scan_hit) begin
          res_hit_nxt   = 1'b1;
          res_idx_nxt   = cmp_idx_r;
          res_first_nxt = scan_s;
          res_value_nxt = scan_last ? fceg_pkg::MARK_END : e_p1_r[27:0];
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_DONE;
        end else if (!scan_issue && !cmp_vld_r) begin
          // every loaded file checked, entry stays bad
          state_nxt = ST_DONE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(scan_issue);
          cmp_vld_nxt  = scan_issue;
          cmp_idx_nxt  = scan_cnt_r[FIDX_W-1:0];
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      files_loaded_r  <= '0;
      offset_r        <= '0;
      scan_cnt_r      <= '0;
      cmp_vld_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      fat_type_r      <= 2'd1;
      cluster_shift_r <= 5'd9;
      root_clusters_r <= 16'd0;
    end else begin
      state_r        <= state_nxt;
      files_loaded_r <= files_loaded_nxt;
      offset_r       <= offset_nxt;
      scan_cnt_r     <= scan_cnt_nxt;
      cmp_vld_r      <= cmp_vld_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fceg_pkg::CFG_FAT_TYPE: fat_type_r      <= cfg_data[1:0];
          fceg_pkg::CFG_SHIFT:    cluster_shift_r <= cfg_data[4:0];
          fceg_pkg::CFG_ROOT:     root_clusters_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      size_r <= in_file_size;
      e_r    <= in_entry_index;
      e_p1_r <= {1'b0, in_entry_index} + 29'd1;
    end
    clusters_r   <= clusters_nxt;
    start_r      <= start_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_value_r  <= res_value_nxt;
    res_hit_r    <= res_hit_nxt;
    res_idx_r    <= res_idx_nxt;
    res_first_r  <= res_first_nxt;
    res_status_r <= res_status_nxt;
    if ((state_r == ST_DONE) && out_free) begin
      out_value_r  <= res_value_r & mask;
      out_hit_r    <= res_hit_r;
      out_idx_r    <= res_idx_r;
      out_first_r  <= res_first_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_value   = out_value_r;
  assign out_in_file       = out_hit_r;
  assign out_file_index    = 4'(out_idx_r);
  assign out_first_cluster = out_first_r;
  assign out_status        = out_status_r;

  // checks
  `FCEG_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
    files_loaded_r <= CNT_W'(fceg_pkg::MAX_FILES), "file count beyond table depth")
  `FCEG_ASSERT_NXT(a_accept_busy, clk, rst_n, in_acc,
    state_r != ST_IDLE, "sequencer still idle after an accepted item")
  `FCEG_ASSERT_IMP(a_read_bound, clk, rst_n, ram_re,
    scan_cnt_r < files_loaded_r, "file table read beyond loaded entries")
  `FCEG_ASSERT_IMP(a_hit_ok, clk, rst_n, out_valid_r && out_hit_r,
    out_status_r == fceg_pkg::STAT_OK, "query hit with a non-ok status")

endmodule

`default_nettype wire

FILE: tb/fat_chain_entry_generator_check.sv
// ----------------------------------------------------------------------------
// fat chain entry checker
// watches the item, result and register channels of the entry generator,
// keeps its own copy of the file table and compares every result transfer
// ----------------------------------------------------------------------------
module fceg_entry_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_file_size,
  input  logic [27:0] in_entry_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [27:0] out_entry_value,
  input  logic        out_in_file,
  input  logic [3:0]  out_file_index,
  input  logic [27:0] out_first_cluster,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [27:0] value;
    logic        in_file;
    logic [3:0]  file_index;
    logic [27:0] first_cluster;
    logic [1:0]  status;
  } fat_answer_t;

  // register copies
  logic [1:0]  fat_type_q;
  logic [4:0]  shift_q;
  logic [15:0] root_q;

  // file table copy
  logic [27:0] run_first [fceg_pkg::MAX_FILES];
  logic [23:0] run_len   [fceg_pkg::MAX_FILES];
  int unsigned n_files;
  logic [27:0] next_offset;

  fat_answer_t pending_answers [$];
  int          n_bad = 0;
  int          n_seen = 0;

  function automatic fat_answer_t compute_answer(input logic [1:0] mode,
                                                 input logic [31:0] size,
                                                 input logic [27:0] cl);
    fat_answer_t r;
    logic [27:0] mask;
    logic [63:0] base, start, nclust, s, n;
    int unsigned sh;
    int          i;
    logic        found;
    r = '0;
    if (fat_type_q[1]) begin
      mask = 28'h0fffffff;
    end else if (fat_type_q == fceg_pkg::FAT12) begin
      mask = 28'h0000fff;
    end else begin
      mask = 28'h000ffff;
    end
    base = 64'd2 + (fat_type_q[1] ? 64'(root_q) : 64'd0);
    case (mode)
      fceg_pkg::MODE_CLEAR: begin
        n_files     = 0;
        next_offset = '0;
      end
      fceg_pkg::MODE_LOAD: begin
        if (n_files >= fceg_pkg::MAX_FILES) begin
          r.status = fceg_pkg::STAT_FULL;
        end else begin
          sh     = (shift_q < fceg_pkg::MIN_SHIFT) ? 9 : shift_q;
          nclust = (64'(size) + ((64'd1 << sh) - 64'd1)) >> sh;
          start  = base + 64'(next_offset);
          r.file_index = n_files[3:0];
          if (nclust != 0 && start + nclust > 64'(mask) - 64'd8) begin
            r.status = fceg_pkg::STAT_EXH;
          end else begin
            run_first[n_files] = start[27:0];
            run_len[n_files]   = nclust[23:0];
            n_files++;
            next_offset     = next_offset + nclust[27:0];
            r.first_cluster = (nclust != 0) ? start[27:0] : 28'd0;
          end
        end
      end
      fceg_pkg::MODE_QUERY: begin
        if (cl == 28'd0) begin
          r.value = fceg_pkg::MARK_MEDIA;
        end else if (cl == 28'd1) begin
          r.value = fceg_pkg::MARK_END;
        end else if (fat_type_q[1] && 64'(cl) < base) begin
          r.value = (64'(cl) + 64'd1 < base) ? cl + 28'd1 : fceg_pkg::MARK_END;
        end else begin
          r.value = fceg_pkg::MARK_BAD;
          found   = 1'b0;
          for (i = 0; i < n_files; i++) begin
            s = 64'(run_first[i]);
            n = 64'(run_len[i]);
            if (!found && n != 0 && 64'(cl) >= s && 64'(cl) < s + n) begin
              found           = 1'b1;
              r.in_file       = 1'b1;
              r.file_index    = i[3:0];
              r.first_cluster = run_first[i];
              r.value         = (64'(cl) + 64'd1 < s + n) ? cl + 28'd1 : fceg_pkg::MARK_END;
            end
          end
        end
        r.value = r.value & mask;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input logic [27:0] got, input logic [27:0] want);
    n_bad++;
    $display("mismatch on result %0d: %s is %h, expected %h", n_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    fat_answer_t want;
    if (!rst_n) begin
      fat_type_q  = 2'd1;
      shift_q     = 5'd9;
      root_q      = '0;
      n_files     = 0;
      next_offset = '0;
      pending_answers.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_seen++;
        if (pending_answers.size() == 0) begin
          report("unexpected transfer, entry_value", out_entry_value, 28'd0);
        end else begin
          want = pending_answers.pop_front();
          if (out_entry_value !== want.value)
            report("entry_value", out_entry_value, want.value);
          if (out_in_file !== want.in_file)
            report("in_file", 28'(out_in_file), 28'(want.in_file));
          if (out_file_index !== want.file_index)
            report("file_index", 28'(out_file_index), 28'(want.file_index));
          if (out_first_cluster !== want.first_cluster)
            report("first_cluster", out_first_cluster, want.first_cluster);
          if (out_status !== want.status)
            report("status", 28'(out_status), 28'(want.status));
        end
      end
      if (in_valid && !in_stall)
        pending_answers.push_back(compute_answer(in_mode, in_file_size, in_entry_index));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fceg_pkg::CFG_FAT_TYPE: fat_type_q = cfg_data[1:0];
          fceg_pkg::CFG_SHIFT:    shift_q    = cfg_data[4:0];
          fceg_pkg::CFG_ROOT:     root_q     = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_answers.size();
    mismatches  <= n_bad;
  end

endmodule

FILE: tb/fat_chain_entry_generator_test.sv
// ----------------------------------------------------------------------------
// fat chain entry generator testbench
// directed and random load, query and clear items over several table formats
// and cluster sizes, with random gaps and back-pressure on both channels; a
// separate checker predicts each result and counts mismatches
// ----------------------------------------------------------------------------
module fat_chain_entry_generator_test;

  // fat type codes beyond the one the package names
  localparam logic [1:0] FAT16_TYPE = 2'd1;
  localparam logic [1:0] FAT32_TYPE = 2'd2;
  localparam logic [1:0] FAT_SPARE  = 2'd3;

  // cycles with no transfer on any channel before the run is abandoned
  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = fceg_pkg::MODE_CLEAR;
  logic [31:0] in_file_size = '0;
  logic [27:0] in_entry_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [27:0] out_entry_value;
  logic        out_in_file;
  logic [3:0]  out_file_index;
  logic [27:0] out_first_cluster;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = fceg_pkg::CFG_FAT_TYPE;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int outstanding;

  // idle percentages for each side
  int send_idle = 34;
  int recv_idle = 63;

  // settings as last written, used only to aim the stimulus
  logic [1:0]  cur_type = FAT16_TYPE;
  logic [4:0]  cur_shift = 5'd9;
  logic [15:0] cur_root = '0;

  int n_clears = 0, n_loads = 0, n_queries = 0, n_spare = 0, n_settings = 1;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fat_chain_entry_generator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_file_size      (in_file_size),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entry_value   (out_entry_value),
    .out_in_file       (out_in_file),
    .out_file_index    (out_file_index),
    .out_first_cluster (out_first_cluster),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  fceg_entry_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_file_size      (in_file_size),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entry_value   (out_entry_value),
    .out_in_file       (out_in_file),
    .out_file_index    (out_file_index),
    .out_first_cluster (out_first_cluster),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[fat_chain_entry_generator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one item transfer; valid stays high afterwards so back-to-back items
  // never drop it, an idle gap lowers it first
  task automatic send_item(input logic [1:0] mode, input logic [31:0] size,
                           input logic [27:0] cl);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_file_size   <= size;
    in_entry_index <= cl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (mode)
      fceg_pkg::MODE_CLEAR: n_clears++;
      fceg_pkg::MODE_LOAD:  n_loads++;
      fceg_pkg::MODE_QUERY: n_queries++;
      default:              n_spare++;
    endcase
  endtask

  // hold off the sender until every outstanding result has been taken
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // write all three registers back to back; spare bits of the data carry noise
  task automatic set_config(input logic [1:0] ft, input logic [4:0] sh,
                            input logic [15:0] root);
    logic [1:0]  idx [3];
    logic [15:0] val [3];
    logic [31:0] junk;
    int          k;
    drain;
    junk   = $urandom;
    idx[0] = fceg_pkg::CFG_FAT_TYPE;
    val[0] = {junk[13:0], ft};
    idx[1] = fceg_pkg::CFG_SHIFT;
    val[1] = {junk[26:16], sh};
    idx[2] = fceg_pkg::CFG_ROOT;
    val[2] = root;
    cur_type  = ft;
    cur_shift = sh;
    cur_root  = root;
    n_settings++;
    cfg_valid <= 1'b1;
    for (k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // byte size that rounds up to exactly nclust clusters, saturated to 32 bits
  function automatic logic [31:0] size_for(input int unsigned nclust);
    int unsigned sh;
    logic [63:0] unit, sz;
    sh   = (cur_shift < fceg_pkg::MIN_SHIFT) ? 9 : cur_shift;
    unit = 64'd1 << sh;
    sz   = (64'(nclust) - 64'd1) * unit + 64'd1 + ({$urandom, $urandom} % unit);
    if (nclust == 0) sz = '0;
    return (sz > 64'hffffffff) ? 32'hffffffff : sz[31:0];
  endfunction

  // cluster number aimed at the interesting parts of the table
  function automatic logic [27:0] pick_cluster();
    logic [27:0] base;
    int unsigned r;
    base = 28'd2 + (cur_type[1] ? 28'(cur_root) : 28'd0);
    r    = $urandom_range(99);
    if (r < 10) return 28'($urandom_range(0, 1));
    if (r < 25) return 28'($urandom_range(2, int'(base) + 1));
    if (r < 85) return base + 28'($urandom_range(0, 300));
    return 28'($urandom);
  endfunction

  // mostly well-formed runs: an optional clear, then loads of a few clusters
  // mixed with queries into the table; the rest is unaimed noise
  task automatic run_items(input int count);
    int          done_n, k, len;
    int unsigned r;
    done_n = 0;
    while (done_n < count) begin
      r = $urandom_range(99);
      if (r < 80) begin
        if ($urandom_range(2) == 0) begin
          send_item(fceg_pkg::MODE_CLEAR, $urandom, 28'($urandom));
          done_n++;
        end
        len = $urandom_range(2, 24);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(99) < 45)
            send_item(fceg_pkg::MODE_LOAD, size_for($urandom_range(0, 12)), 28'($urandom));
          else
            send_item(fceg_pkg::MODE_QUERY, $urandom, pick_cluster());
        end
        done_n += len;
      end else begin
        r = $urandom_range(3);
        send_item(2'(r), $urandom, 28'($urandom));
        if (2'(r) != fceg_pkg::MODE_NONE) done_n++;
      end
    end
  endtask

  initial begin
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fat16, 512-byte clusters, data from cluster 2
    send_item(fceg_pkg::MODE_NONE, 32'hffffffff, 28'hfffffff);  // unused mode, all ones
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd0);                 // media marker
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd1);                 // end marker
    send_item(fceg_pkg::MODE_LOAD, 32'd0, '0);       // empty file takes an index only
    send_item(fceg_pkg::MODE_LOAD, 32'd1, '0);       // one cluster at 2
    send_item(fceg_pkg::MODE_LOAD, 32'd513, '0);     // two clusters, 3 and 4
    send_item(fceg_pkg::MODE_LOAD, 32'hffffffff, '0);  // too big for fat16
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd2);      // single-cluster run ends at once
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd3);      // link inside a run
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd4);      // last cluster of a run
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd5);      // past every run
    send_item(fceg_pkg::MODE_QUERY, '0, 28'hfffffff);  // highest cluster number
    // fill the table to its last slot, then one load more finds it full
    for (k = 0; k < 14; k++) send_item(fceg_pkg::MODE_LOAD, 32'(k * 512), '0);
    run_items(90);

    // fat32 with a short root chain; shift below the floor acts as 512 bytes
    set_config(FAT32_TYPE, 5'd5, 16'd3);
    send_item(fceg_pkg::MODE_CLEAR, '0, '0);
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd2);      // root chain link
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd4);      // root chain end
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd5);      // first data cluster, empty table
    send_item(fceg_pkg::MODE_LOAD, 32'd1000, '0);    // two clusters after the root
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd5);
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd6);
    run_items(90);

    // swap the idling sides; fat12 without a clear keeps the earlier runs
    send_idle = 63;
    recv_idle = 34;
    set_config(fceg_pkg::FAT12, 5'd9, 16'd0);
    run_items(90);

    // spare fat type acts as fat32, largest root chain and 4 MiB clusters
    set_config(FAT_SPARE, 5'd22, 16'hffff);
    send_item(fceg_pkg::MODE_CLEAR, '0, '0);
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd65536);    // end of the long root chain
    send_item(fceg_pkg::MODE_LOAD, 32'hffffffff, '0);  // 1024 clusters from 65537
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd66560);    // end of that run, 28-bit marker
    send_item(fceg_pkg::MODE_QUERY, '0, 28'd65537);
    run_items(90);

    // no idling from here on
    send_idle = 0;
    recv_idle = 0;
    set_config(FAT32_TYPE, 5'd31, 16'd0);
    run_items(90);
    set_config(FAT16_TYPE, 5'd0, 16'hffff);
    run_items(90);
    set_config(FAT32_TYPE, 5'd12, 16'd17);
    run_items(90);

    drain;
    repeat (40) @(posedge clk);

    $display("covered %0d clears, %0d loads, %0d queries and %0d unused-mode items",
             n_clears, n_loads, n_queries, n_spare);
    $display("across %0d register settings, with and without gaps on both channels",
             n_settings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[fat_chain_entry_generator] OK");
    end else begin
      $display("[fat_chain_entry_generator] ERROR");
    end
    $finish;
  end

endmodule
